### src/itwt_pkg.sv
package itwt_pkg;

	localparam int VAL_W  = 32;
	localparam int DIGITS = 10;
	localparam int TOK_W  = 6;
	localparam int CNT_W  = $clog2(VAL_W);

	localparam logic [TOK_W-1:0] TOK_ZERO       = 6'd0;
	localparam logic [TOK_W-1:0] TOK_TEN        = 6'd10;
	localparam logic [TOK_W-1:0] TOK_TENS_BASE  = 6'd18;
	localparam logic [TOK_W-1:0] TOK_HUNDRED    = 6'd28;
	localparam logic [TOK_W-1:0] TOK_SCALE_BASE = 6'd28;
	localparam logic [TOK_W-1:0] TOK_NEGATIVE   = 6'd32;

	typedef logic [DIGITS-1:0][3:0] bcd_t;

	typedef struct packed {
		logic done;
		bcd_t digits;
	} conv_t;

	typedef struct packed {
		logic busy;
		logic fin;
	} emit_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NEG,
		ST_GROUP,
		ST_FLUSH
	} emit_state_t;

endpackage

### src/itwt_bcd.sv
module itwt_bcd (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [itwt_pkg::VAL_W-1:0]    mag,
	output itwt_pkg::conv_t               conv
);

	logic [itwt_pkg::VAL_W-1:0]     bin_q;
	itwt_pkg::bcd_t                 bcd_q;
	itwt_pkg::bcd_t                 adj;
	logic [itwt_pkg::DIGITS*4-1:0]  adj_flat;
	logic [itwt_pkg::CNT_W-1:0]     cnt_q;
	logic                           run_q;
	logic                           done_q;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < itwt_pkg::DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		adj_flat = adj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == itwt_pkg::CNT_W'(itwt_pkg::VAL_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (run_q) begin
			bin_q <= {bin_q[itwt_pkg::VAL_W-2:0], 1'b0};
			bcd_q <= {adj_flat[itwt_pkg::DIGITS*4-2:0], bin_q[itwt_pkg::VAL_W-1]};
		end
	end

	assign conv.done   = done_q;
	assign conv.digits = bcd_q;

endmodule

### src/itwt_emit.sv
module itwt_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  itwt_pkg::conv_t             conv,
	input  logic                        neg,
	output logic                        word_valid,
	input  logic                        word_stall,
	output logic [itwt_pkg::TOK_W-1:0]  word,
	output logic                        last,
	output itwt_pkg::emit_stat_t        stat
);

	itwt_pkg::emit_state_t        state_q, state_d;
	itwt_pkg::bcd_t               digits_q;
	logic [1:0]                   gi_q;
	logic [2:0]                   step_q;
	logic [itwt_pkg::TOK_W-1:0]   pend_q;
	logic                         pend_v_q;
	logic [itwt_pkg::TOK_W-1:0]   word_q;
	logic                         last_q;
	logic                         out_v_q;

	logic [3:0]                   h, t, u;
	logic                         tok_v;
	logic [itwt_pkg::TOK_W-1:0]   tok;
	logic                         can_move, adv, active, flush_go, load_out;

	// pick the three digits of the current thousand group
	always_comb begin
		unique case (gi_q)
			2'd3:    begin h = 4'd0;        t = 4'd0;        u = digits_q[9]; end
			2'd2:    begin h = digits_q[8]; t = digits_q[7]; u = digits_q[6]; end
			2'd1:    begin h = digits_q[5]; t = digits_q[4]; u = digits_q[3]; end
			default: begin h = digits_q[2]; t = digits_q[1]; u = digits_q[0]; end
		endcase
	end

	always_comb begin
		state_d = state_q;
		tok_v   = 1'b0;
		tok     = itwt_pkg::TOK_ZERO;
		unique case (state_q)
			itwt_pkg::ST_IDLE: begin
				if (conv.done)
					state_d = neg ? itwt_pkg::ST_NEG : itwt_pkg::ST_GROUP;
			end
			itwt_pkg::ST_NEG: begin
				tok_v = 1'b1;
				tok   = itwt_pkg::TOK_NEGATIVE;
			end
			itwt_pkg::ST_GROUP: begin
				unique case (step_q)
					3'd0: begin
						tok_v = (h != 4'd0);
						tok   = {2'b00, h};
					end
					3'd1: begin
						tok_v = (h != 4'd0);
						tok   = itwt_pkg::TOK_HUNDRED;
					end
					3'd2: begin
						if (t >= 4'd2) begin
							tok_v = 1'b1;
							tok   = itwt_pkg::TOK_TENS_BASE + {2'b00, t};
						end else begin
							tok_v = (t != 4'd0) || (u != 4'd0);
							tok   = t[0] ? itwt_pkg::TOK_TEN + {2'b00, u} : {2'b00, u};
						end
					end
					3'd3: begin
						tok_v = (t >= 4'd2) && (u != 4'd0);
						tok   = {2'b00, u};
					end
					3'd4: begin
						tok_v = (gi_q != 2'd0) && ((h | t | u) != 4'd0);
						tok   = itwt_pkg::TOK_SCALE_BASE + {4'b0000, gi_q};
					end
					default: begin
						tok_v = 1'b0;
					end
				endcase
			end
			itwt_pkg::ST_FLUSH: begin
				if (!out_v_q || !word_stall)
					state_d = itwt_pkg::ST_IDLE;
			end
			default: state_d = itwt_pkg::ST_IDLE;
		endcase
		// a new token pushes the held one out, so hold while the output is full
		adv = active && (!tok_v || !pend_v_q || can_move);
		if (adv && state_q == itwt_pkg::ST_NEG)
			state_d = itwt_pkg::ST_GROUP;
		if (adv && state_q == itwt_pkg::ST_GROUP && step_q == 3'd4 && gi_q == 2'd0)
			state_d = itwt_pkg::ST_FLUSH;
	end

	assign can_move = !out_v_q || !word_stall;
	assign active   = (state_q == itwt_pkg::ST_NEG) || (state_q == itwt_pkg::ST_GROUP);
	assign flush_go = (state_q == itwt_pkg::ST_FLUSH) && can_move;
	assign load_out = (adv && tok_v && pend_v_q) || flush_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= itwt_pkg::ST_IDLE;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			gi_q     <= 2'd3;
			step_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			if (state_q == itwt_pkg::ST_IDLE && conv.done) begin
				pend_v_q <= (conv.digits == '0);
				gi_q     <= 2'd3;
				step_q   <= 3'd0;
			end else begin
				if (adv && tok_v)
					pend_v_q <= 1'b1;
				if (flush_go)
					pend_v_q <= 1'b0;
				if (adv && state_q == itwt_pkg::ST_GROUP) begin
					if (step_q == 3'd4) begin
						step_q <= 3'd0;
						gi_q   <= gi_q - 2'd1;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
			end
			if (load_out)
				out_v_q <= 1'b1;
			else if (!word_stall)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == itwt_pkg::ST_IDLE && conv.done) begin
			digits_q <= conv.digits;
			pend_q   <= itwt_pkg::TOK_ZERO;
		end else if (adv && tok_v) begin
			pend_q <= tok;
		end
		if (load_out) begin
			word_q <= pend_q;
			last_q <= flush_go;
		end
	end

	assign word_valid = out_v_q;
	assign word       = word_q;
	assign last       = last_q;
	assign stat.busy  = (state_q != itwt_pkg::ST_IDLE);
	assign stat.fin   = flush_go;

endmodule

### src/integer_to_word_tokens.sv
// Spells one signed 32-bit value as a run of English word tokens, 1 to 17 beats.
// Without stalls, a value passes through a load, a 32-step shift-and-add-3 converter, 20 group
// steps and a flush before its last word beat; a negative value adds a sign step first.
// Only one value is in flight at a time; input stalls until the last
// token is loaded, and output stalls hold the sequencer.
// Reset clears all control state at once; no clearing pass is needed.
module integer_to_word_tokens (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               value_valid,
	output logic                               value_stall,
	input  logic signed [itwt_pkg::VAL_W-1:0]  value,
	output logic                               word_valid,
	input  logic                               word_stall,
	output logic [itwt_pkg::TOK_W-1:0]         word,
	output logic                               last
);

	logic                         busy_q;
	logic                         neg_q;
	logic                         accept;
	logic [itwt_pkg::VAL_W-1:0]   mag;
	itwt_pkg::conv_t              conv;
	itwt_pkg::emit_stat_t         stat;

	assign value_stall = busy_q;
	assign accept      = value_valid && !busy_q;
	// the most negative value negates to itself, which is right when read unsigned
	assign mag = value[itwt_pkg::VAL_W-1] ? (~value + 1'b1) : value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (stat.fin) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			neg_q <= value[itwt_pkg::VAL_W-1];
	end

	itwt_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.conv   (conv)
	);

	itwt_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.conv       (conv),
		.neg        (neg_q),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word),
		.last       (last),
		.stat       (stat)
	);

	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (word_valid && last))
		else $error("value released without a last beat loaded");

	a_conv_busy: assert property (@(posedge clk) disable iff (!arst_n)
		conv.done |-> (busy_q && !stat.busy))
		else $error("conversion finished outside a value");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> busy_q)
		else $error("sequencer running while input is open");

endmodule

### dv/integer_to_word_tokens_check.sv
module integer_to_word_tokens_check (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               value_valid,
	input  logic                               value_stall,
	input  logic signed [itwt_pkg::VAL_W-1:0]  value,
	input  logic                               word_valid,
	input  logic                               word_stall,
	input  logic [itwt_pkg::TOK_W-1:0]         word,
	input  logic                               last,
	output int                                 fails,
	output int                                 tokens_due,
	output int                                 values_seen,
	output int                                 words_seen
);

	typedef struct packed {
		logic [itwt_pkg::TOK_W-1:0] word;
		logic                       last;
	} token_t;

	token_t spoken_words[$];
	int     fail_count  = 0;
	int     value_count = 0;
	int     word_count  = 0;

	task automatic spell_value(input logic [itwt_pkg::VAL_W-1:0] v);
		logic                       neg;
		logic [itwt_pkg::VAL_W:0]   mag;
		logic [itwt_pkg::VAL_W:0]   rest;
		int                         grp [4];
		int                         h;
		int                         r;
		int                         i;
		logic [itwt_pkg::TOK_W-1:0] toks [17];
		int                         n;
		token_t                     t;
		neg  = v[itwt_pkg::VAL_W-1];
		n    = 0;
		// widen before negating so the most negative value keeps its magnitude
		mag  = neg ? ({1'b1, {itwt_pkg::VAL_W{1'b0}}} - {1'b0, v}) : {1'b0, v};
		rest = mag;
		for (i = 0; i < 4; i++) begin
			grp[i] = int'(rest % 1000);
			rest   = rest / 1000;
		end
		if (mag == 0) begin
			toks[n] = itwt_pkg::TOK_ZERO;
			n++;
		end else begin
			if (neg) begin
				toks[n] = itwt_pkg::TOK_NEGATIVE;
				n++;
			end
			for (i = 3; i >= 0; i--) begin
				if (grp[i] == 0) begin
					continue;
				end
				h = grp[i] / 100;
				r = grp[i] % 100;
				if (h != 0) begin
					toks[n] = itwt_pkg::TOK_W'(h);
					n++;
					toks[n] = itwt_pkg::TOK_HUNDRED;
					n++;
				end
				if (r >= 20) begin
					toks[n] = itwt_pkg::TOK_TENS_BASE + itwt_pkg::TOK_W'(r / 10);
					n++;
					r = r % 10;
				end
				if (r != 0) begin
					toks[n] = itwt_pkg::TOK_W'(r);
					n++;
				end
				if (i > 0) begin
					toks[n] = itwt_pkg::TOK_SCALE_BASE + itwt_pkg::TOK_W'(i);
					n++;
				end
			end
		end
		for (i = 0; i < n; i++) begin
			t.word = toks[i];
			t.last = (i == n - 1);
			spoken_words.insert(spoken_words.size(), t);
		end
	endtask

	always @(posedge clk) begin
		token_t want;
		if (arst_n) begin
			if (value_valid && !value_stall) begin
				spell_value(value);
				value_count++;
			end
			if (word_valid && !word_stall) begin
				word_count++;
				if (spoken_words.size() == 0) begin
					$display("%0t: word beat %0d last %0b with nothing expected",
						$time, word, last);
					fail_count++;
				end else begin
					want = spoken_words[0];
					spoken_words.delete(0);
					if (word !== want.word) begin
						$display("%0t: word expected %0d actual %0d", $time, want.word, word);
						fail_count++;
					end
					if (last !== want.last) begin
						$display("%0t: last expected %0b actual %0b", $time, want.last, last);
						fail_count++;
					end
				end
			end
		end
		fails       <= fail_count;
		tokens_due  <= spoken_words.size();
		values_seen <= value_count;
		words_seen  <= word_count;
	end

endmodule

### dv/integer_to_word_tokens_test.sv
module integer_to_word_tokens_test;

	localparam int PHASE_ITEMS = 95;
	localparam int FLOOD_ITEMS = 24;
	localparam int HOLD_CYCLES = 600;

	logic                              clk;
	logic                              arst_n      = 1'b0;
	logic                              value_valid = 1'b0;
	logic                              value_stall;
	logic signed [itwt_pkg::VAL_W-1:0] value       = '0;
	logic                              word_valid;
	logic                              word_stall  = 1'b0;
	logic [itwt_pkg::TOK_W-1:0]        word;
	logic                              last;

	int fails;
	int tokens_due;
	int values_seen;
	int words_seen;

	int idle_pct    = 0;
	int stall_pct   = 0;
	logic flood     = 1'b0;
	logic held_once = 1'b0;
	int hold_left   = 0;

	integer_to_word_tokens i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.word_valid  (word_valid),
		.word_stall  (word_stall),
		.word        (word),
		.last        (last)
	);

	integer_to_word_tokens_check i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.word_valid  (word_valid),
		.word_stall  (word_stall),
		.word        (word),
		.last        (last),
		.fails       (fails),
		.tokens_due  (tokens_due),
		.values_seen (values_seen),
		.words_seen  (words_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	// hold the word channel off for a long stretch once the flood starts
	always @(posedge clk) begin
		if (hold_left > 0) begin
			word_stall <= 1'b1;
			hold_left  <= hold_left - 1;
		end else if (flood && !held_once) begin
			word_stall <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			held_once  <= 1'b1;
		end else begin
			word_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_value(input logic [itwt_pkg::VAL_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			value_valid <= 1'b0;
			@(posedge clk);
		end
		value_valid <= 1'b1;
		value       <= v;
		@(posedge clk);
		while (value_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic wait_drained;
		value_valid <= 1'b0;
		@(posedge clk);
		while (tokens_due != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [itwt_pkg::VAL_W-1:0] draw_value;
		int     kind;
		longint mag;
		longint scale;
		kind = $urandom_range(9);
		mag  = 0;
		if (kind <= 2) begin
			return $urandom;
		end
		if (kind == 8) begin
			return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
				: 32'h7FFF_FFFF - $urandom_range(3);
		end
		if (kind <= 4) begin
			mag = $urandom_range(999);
		end else if (kind <= 7) begin
			// drop whole groups now and then so that empty groups get skipped
			mag = longint'($urandom_range(2)) * 1000000000
				+ longint'(($urandom_range(2) == 0) ? 0 : $urandom_range(999)) * 1000000
				+ longint'(($urandom_range(2) == 0) ? 0 : $urandom_range(999)) * 1000
				+ longint'(($urandom_range(2) == 0) ? 0 : $urandom_range(999));
			mag = mag % 64'd2147483649;
		end else begin
			scale = ($urandom_range(2) == 0) ? 1 : ($urandom_range(1) ? 1000 : 1000000);
			mag   = longint'($urandom_range(99)) * scale;
		end
		if ($urandom_range(1)) begin
			return itwt_pkg::VAL_W'(-mag);
		end
		if (mag > 64'd2147483647) begin
			mag = mag - 1000000000;
		end
		return itwt_pkg::VAL_W'(mag);
	endfunction

	logic [itwt_pkg::VAL_W-1:0] directed [] = '{
		32'd0, 32'd1, -32'sd1, 32'd7, 32'd10, 32'd11, 32'd13, 32'd19, 32'd20,
		32'd21, 32'd99, 32'd100, 32'd110, 32'd119, 32'd999, 32'd1000, 32'd1001,
		32'd100000, 32'd1000000, 32'd1000001, 32'd1000000000, 32'd1002003004,
		32'h7FFF_FFFF, 32'h8000_0000, -32'sd1000010
	};

	initial begin
		int i;
		int ph;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < directed.size(); i++) begin
			send_value(directed[i]);
		end

		// sweep idle/stall mixes: none, sender idle, receiver stalling, both
		for (ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1) ? 87 : (ph == 3) ? 29 : 0;
			stall_pct <= (ph == 2) ? 87 : (ph == 3) ? 29 : 0;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				send_value(draw_value());
			end
			if (ph == 1) begin
				wait_drained();
			end
		end

		// keep offering beats while the word channel is held off
		idle_pct  = 0;
		stall_pct <= 0;
		flood     <= 1'b1;
		for (i = 0; i < FLOOD_ITEMS; i++) begin
			send_value(draw_value());
		end
		flood <= 1'b0;

		wait_drained();
		repeat (100) @(posedge clk);

		$display("run: %0d values spelled as %0d word beats,", values_seen, words_seen);
		$display("run: idle and stall mixes plus one long hold-off on the word channel");
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
